// ===== src/mrc_pkg.sv =====
// mrc_pkg: shared types and constants for the meeting room counter
// no dependencies; compiled first
`default_nettype none

package mrc_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned RoomsW = 9;

  typedef enum logic [3:0] {
    MRC_IDLE,
    MRC_CHK_ROOT,
    MRC_POP_LAST,
    MRC_SD_L,
    MRC_SD_R,
    MRC_SD_RC,
    MRC_PUSH_INIT,
    MRC_SU_P,
    MRC_SU_C,
    MRC_DONE
  } mrc_state_e;

  typedef struct packed {
    logic                     first_of_set;
    logic signed [DataW-1:0]  start_time;
    logic signed [DataW-1:0]  end_time;
  } mrc_req_t;

  typedef struct packed {
    logic [RoomsW-1:0] rooms_needed;
    logic              overflow;
  } mrc_res_t;

endpackage

`default_nettype wire

// ===== src/mrc_if.sv =====
// mrc_if: valid/ready channel interfaces for meeting beats and result beats
// depends on mrc_pkg
`default_nettype none

interface mrc_in_if;
  import mrc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    first_of_set;
  logic signed [DataW-1:0] start_time;
  logic signed [DataW-1:0] end_time;

  modport source (output valid, output first_of_set, output start_time, output end_time,
                  input ready);
  modport sink (input valid, input first_of_set, input start_time, input end_time,
                output ready);
endinterface

interface mrc_out_if;
  import mrc_pkg::*;

  logic              valid;
  logic              ready;
  logic [RoomsW-1:0] rooms_needed;
  logic              overflow;

  modport source (output valid, output rooms_needed, output overflow, input ready);
  modport sink (input valid, input rooms_needed, input overflow, output ready);
endinterface

`default_nettype wire

// ===== src/mrc_ram.sv =====
// mrc_ram: heap storage, one write port and one read port with registered data
// no package dependencies
`default_nettype none

module mrc_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output      logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/mrc_seq.sv =====
// mrc_seq: sequencer that pops and pushes the end-time heap with one shared comparator
// depends on mrc_pkg; drives the write and read ports of mrc_ram
`default_nettype none

module mrc_seq #(
  parameter int unsigned HeapDepth = 256,
  localparam int unsigned AddrW = $clog2(HeapDepth),
  localparam int unsigned CntW  = $clog2(HeapDepth + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output      logic              req_ready_o,
  input  wire mrc_pkg::mrc_req_t req_i,
  output      logic              res_valid_o,
  input  wire logic              res_ready_i,
  output      mrc_pkg::mrc_res_t res_o,
  output      logic              wr_en_o,
  output      logic [AddrW-1:0]  wr_addr_o,
  output      logic [mrc_pkg::DataW-1:0] wr_data_o,
  output      logic              rd_en_o,
  output      logic [AddrW-1:0]  rd_addr_o,
  input  wire logic [mrc_pkg::DataW-1:0] rd_data_i
);
  import mrc_pkg::*;

  // child index math needs room for 2*pos+2
  localparam int unsigned IdxW = AddrW + 2;

  mrc_state_e state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  logic                    ovf_q, ovf_d;
  logic signed [DataW-1:0] start_q, start_d;
  logic signed [DataW-1:0] end_q, end_d;
  logic signed [DataW-1:0] v_q, v_d;
  logic signed [DataW-1:0] bestv_q, bestv_d;
  logic                    best_l_q, best_l_d;
  logic [AddrW-1:0]        pos_q, pos_d;

  logic signed [DataW-1:0] cmp_a, cmp_b;
  logic                    lt;
  logic [IdxW-1:0]         l_idx, r_idx, cnt_ext;
  logic [AddrW-1:0]        par_idx;

  assign l_idx   = {1'b0, pos_q, 1'b1};
  assign r_idx   = l_idx + IdxW'(1);
  assign cnt_ext = IdxW'(count_q);
  assign par_idx = AddrW'((pos_q - AddrW'(1)) >> 1);

  // the single signed comparator, operands picked by state
  always_comb begin
    cmp_a = v_q;
    cmp_b = v_q;
    unique case (state_q)
      MRC_CHK_ROOT: begin
        cmp_a = start_q;
        cmp_b = $signed(rd_data_i);
      end
      MRC_SD_R: begin
        cmp_a = $signed(rd_data_i);
        cmp_b = v_q;
      end
      MRC_SD_RC: begin
        cmp_a = $signed(rd_data_i);
        cmp_b = bestv_q;
      end
      MRC_SU_C: begin
        cmp_a = v_q;
        cmp_b = $signed(rd_data_i);
      end
      default: begin
        cmp_a = v_q;
        cmp_b = v_q;
      end
    endcase
  end

  assign lt = cmp_a < cmp_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MRC_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q  <= start_d;
    end_q    <= end_d;
    v_q      <= v_d;
    bestv_q  <= bestv_d;
    best_l_q <= best_l_d;
    pos_q    <= pos_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    start_d     = start_q;
    end_d       = end_q;
    v_d         = v_q;
    bestv_d     = bestv_q;
    best_l_d    = best_l_q;
    pos_d       = pos_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    wr_en_o     = 1'b0;
    wr_addr_o   = pos_q;
    wr_data_o   = v_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = '0;

    unique case (state_q)
      MRC_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          start_d = req_i.start_time;
          end_d   = req_i.end_time;
          ovf_d   = 1'b0;
          if (req_i.first_of_set) begin
            count_d = '0;
          end
          rd_en_o   = 1'b1;
          rd_addr_o = '0;
          state_d   = MRC_CHK_ROOT;
        end
      end
      MRC_CHK_ROOT: begin
        // pop when start is at or after the smallest end
        if (count_q != '0 && !lt) begin
          rd_en_o   = 1'b1;
          rd_addr_o = AddrW'(count_q - CntW'(1));
          state_d   = MRC_POP_LAST;
        end else begin
          state_d = MRC_PUSH_INIT;
        end
      end
      MRC_POP_LAST: begin
        v_d     = $signed(rd_data_i);
        count_d = count_q - CntW'(1);
        pos_d   = '0;
        state_d = MRC_SD_L;
      end
      MRC_SD_L: begin
        if (l_idx < cnt_ext) begin
          rd_en_o   = 1'b1;
          rd_addr_o = AddrW'(l_idx);
          state_d   = MRC_SD_R;
        end else begin
          wr_en_o = 1'b1;
          state_d = MRC_PUSH_INIT;
        end
      end
      MRC_SD_R: begin
        best_l_d = lt;
        bestv_d  = lt ? $signed(rd_data_i) : v_q;
        if (r_idx < cnt_ext) begin
          rd_en_o   = 1'b1;
          rd_addr_o = AddrW'(r_idx);
          state_d   = MRC_SD_RC;
        end else if (lt) begin
          wr_en_o   = 1'b1;
          wr_data_o = rd_data_i;
          pos_d     = AddrW'(l_idx);
          state_d   = MRC_SD_L;
        end else begin
          wr_en_o = 1'b1;
          state_d = MRC_PUSH_INIT;
        end
      end
      MRC_SD_RC: begin
        // equal children keep the left one, equal to parent stays put
        if (lt) begin
          wr_en_o   = 1'b1;
          wr_data_o = rd_data_i;
          pos_d     = AddrW'(r_idx);
          state_d   = MRC_SD_L;
        end else if (best_l_q) begin
          wr_en_o   = 1'b1;
          wr_data_o = bestv_q;
          pos_d     = AddrW'(l_idx);
          state_d   = MRC_SD_L;
        end else begin
          wr_en_o = 1'b1;
          state_d = MRC_PUSH_INIT;
        end
      end
      MRC_PUSH_INIT: begin
        if (count_q == CntW'(HeapDepth)) begin
          ovf_d   = 1'b1;
          state_d = MRC_DONE;
        end else begin
          v_d     = end_q;
          pos_d   = AddrW'(count_q);
          state_d = MRC_SU_P;
        end
      end
      MRC_SU_P: begin
        if (pos_q == '0) begin
          wr_en_o = 1'b1;
          count_d = count_q + CntW'(1);
          state_d = MRC_DONE;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = par_idx;
          state_d   = MRC_SU_C;
        end
      end
      MRC_SU_C: begin
        if (lt) begin
          wr_en_o   = 1'b1;
          wr_data_o = rd_data_i;
          pos_d     = par_idx;
          state_d   = MRC_SU_P;
        end else begin
          wr_en_o = 1'b1;
          count_d = count_q + CntW'(1);
          state_d = MRC_DONE;
        end
      end
      MRC_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = MRC_IDLE;
        end
      end
      default: begin
        state_d = MRC_IDLE;
      end
    endcase
  end

  assign res_o.rooms_needed = RoomsW'(count_q);
  assign res_o.overflow     = ovf_q;

endmodule

`default_nettype wire

// ===== src/meeting_room_count_min_heap.sv =====
// meeting_room_count_min_heap: min-heap of end times, one result beat per meeting beat.
// per meeting beat the sequencer reads the root; if the heap is not empty and the start is at
// or after the root, it pops the last entry and sifts it down (SD_L, SD_R and, with a right
// child, SD_RC per level); it then pushes the end time with a sift-up (SU_P, SU_C per level),
// or drops the insert on a full heap; all on one comparator and one read port of the heap memory.
// one meeting in work at a time, so the next input beat waits until the result is handed to
// the output register, and waits longer while the output register is held.
// reset: asynchronous, empties the heap and the output register; memory is not cleared.
// depends on mrc_pkg, mrc_if, mrc_ram and mrc_seq
`default_nettype none

module meeting_room_count_min_heap #(
  parameter int unsigned HEAP_DEPTH = 256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mrc_in_if.sink     in_i,
  mrc_out_if.source  out_o
);
  import mrc_pkg::*;

  localparam int unsigned AddrW = $clog2(HEAP_DEPTH);

  mrc_req_t         req;
  mrc_res_t         res;
  logic             res_valid;
  logic             res_ready;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [DataW-1:0] wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [DataW-1:0] rd_data;

  logic              out_valid_q;
  logic [RoomsW-1:0] out_rooms_q;
  logic              out_ovf_q;

  assign req.first_of_set = in_i.first_of_set;
  assign req.start_time   = in_i.start_time;
  assign req.end_time     = in_i.end_time;

  mrc_seq #(
    .HeapDepth (HEAP_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_ready_o (in_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  mrc_ram #(
    .Depth (HEAP_DEPTH),
    .Width (DataW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // output register lets the next meeting start while a result beat waits
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_rooms_q <= res.rooms_needed;
      out_ovf_q   <= res.overflow;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.rooms_needed = out_rooms_q;
  assign out_o.overflow     = out_ovf_q;

  // a dropped insert only happens on a full heap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.overflow |-> res.rooms_needed == RoomsW'(HEAP_DEPTH))
    else $error("overflow flagged with heap not full");

  // sequencer never takes a meeting while holding a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !res_valid)
    else $error("input ready while result pending");

  // output register only fills from a handed-over result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(res_valid))
    else $error("output valid without a result");

endmodule

`default_nettype wire
